### rtl/core/dqe_pkg.sv
// dqe_pkg: shared sizes, operation codes and control types for the deque core
// depends on nothing
`default_nettype none

package dqe_pkg;

   localparam int DEPTH = 32;
   localparam int KEY_W = 8;
   localparam int MODE_W = 3;
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef logic [KEY_W-1:0] key_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH_FRONT = 3'd0,
      MODE_PUSH_BACK  = 3'd1,
      MODE_DUMP       = 3'd2,
      MODE_POP_FRONT  = 3'd3,
      MODE_POP_BACK   = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_PUSH_FRONT,
      OP_PUSH_BACK,
      OP_POP_FRONT,
      OP_ROTATE
   } op_type;

   typedef enum logic {
      ST_IDLE,
      ST_DUMP
   } state_type;

   typedef struct packed {
      op_type  op;
      key_type key;
      cnt_type count;
   } chain_ctl_type;

   typedef struct packed {
      op_type  op;
      key_type key;
      logic    is_tail;
      logic    is_back;
   } cell_ctl_type;

endpackage

`default_nettype wire

### rtl/core/dqe_if.sv
// dqe_req_if / dqe_rsp_if: valid-ready channels for operation and result beats
// depends on dqe_pkg
`default_nettype none

interface dqe_req_if;
   import dqe_pkg::*;
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   key_type           key_in;

   modport source (output valid, output mode, output key_in, input ready);
   modport sink (input valid, input mode, input key_in, output ready);
endinterface

interface dqe_rsp_if;
   import dqe_pkg::*;
   logic    valid;
   logic    ready;
   key_type key_out;
   logic    is_empty;
   logic    overflow;
   logic    is_last;

   modport source (output valid, output key_out, output is_empty, output overflow,
                   output is_last, input ready);
   modport sink (input valid, input key_out, input is_empty, input overflow,
                 input is_last, output ready);
endinterface

`default_nettype wire

### rtl/core/dqe_cell.sv
// dqe_cell: one slot of the deque chain, loads from its neighbors, the head cell or the new key
// depends on dqe_pkg
`default_nettype none

module dqe_cell
   import dqe_pkg::*;
(
   input  wire logic         clock,
   input  wire cell_ctl_type ctl,
   input  wire key_type      prev_key,
   input  wire key_type      next_key,
   input  wire key_type      head_key,
   output key_type           cell_key
);

   key_type data_ff;
   key_type data_in;

   always_comb begin
      data_in = data_ff;
      unique case (ctl.op)
         OP_HOLD:       data_in = data_ff;
         OP_PUSH_FRONT: data_in = prev_key;
         OP_PUSH_BACK:  data_in = ctl.is_tail ? ctl.key : data_ff;
         OP_POP_FRONT:  data_in = next_key;
         OP_ROTATE:     data_in = ctl.is_back ? head_key : next_key;
         default:       data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign cell_key = data_ff;

endmodule

`default_nettype wire

### rtl/core/dqe_chain.sv
// dqe_chain: row of deque cells, front at cell zero, with slot decode from the count
// depends on dqe_pkg, dqe_cell
`default_nettype none

module dqe_chain
   import dqe_pkg::*;
(
   input  wire logic          clock,
   input  wire chain_ctl_type ctl,
   output key_type            head_key,
   output key_type            back_key
);

   key_type      cell_keys [DEPTH];
   key_type      back_terms [DEPTH];
   cell_ctl_type cell_ctl [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      key_type prev_k;
      key_type next_k;

      assign cell_ctl[i].op      = ctl.op;
      assign cell_ctl[i].key     = ctl.key;
      assign cell_ctl[i].is_tail = (ctl.count == CNT_W'(i));
      assign cell_ctl[i].is_back = (ctl.count == CNT_W'(i + 1));

      if (i == 0) begin : g_first
         assign prev_k = ctl.key;
      end else begin : g_mid
         assign prev_k = cell_keys[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign next_k = cell_keys[i];
      end else begin : g_rest
         assign next_k = cell_keys[i+1];
      end

      dqe_cell u_cell (
         .clock    (clock),
         .ctl      (cell_ctl[i]),
         .prev_key (prev_k),
         .next_key (next_k),
         .head_key (cell_keys[0]),
         .cell_key (cell_keys[i])
      );

      assign back_terms[i] = cell_ctl[i].is_back ? cell_keys[i] : '0;
   end

   always_comb begin
      back_key = '0;
      for (int i = 0; i < DEPTH; i++) begin
         back_key = back_key | back_terms[i];
      end
   end

   assign head_key = cell_keys[0];

endmodule

`default_nettype wire

### rtl/core/double_ended_queue_core.sv
// double_ended_queue_core: bounded deque of byte keys, control and result register
// depends on dqe_pkg, dqe_if, dqe_chain
//
// req_bus carries one operation per beat: mode (push front, push back, dump,
// pop front, pop back) and key_in. rsp_bus returns result beats with key_out,
// is_empty, overflow and is_last; is_last marks the final beat of an operation.
// pushes that succeed give no beat; a push into a full queue gives one overflow
// beat; pops give one beat; a dump gives one beat per stored key, front first,
// or a single empty beat. modes five to seven are taken and ignored.
// a push or pop result appears in the output register on the next cycle, so
// one operation per cycle is sustained while the receiver takes every beat.
// a dump holds req ready low and streams one key per cycle while the receiver
// takes every beat, by rotating the cell chain once around the stored keys.
// reset empties the queue and drops any pending result; no clearing pass.
// when the receiver stalls, the result register holds and req ready drops
// until the register can take the next beat.
`default_nettype none

module double_ended_queue_core
   import dqe_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   dqe_req_if.sink   req_bus,
   dqe_rsp_if.source rsp_bus
);

   state_type     state_ff, state_in;
   cnt_type       count_ff, count_in;
   cnt_type       dump_left_ff, dump_left_in;
   logic          rsp_valid_ff, rsp_valid_in;
   key_type       rsp_key_ff, rsp_key_in;
   logic          rsp_empty_ff, rsp_empty_in;
   logic          rsp_ovf_ff, rsp_ovf_in;
   logic          rsp_last_ff, rsp_last_in;

   chain_ctl_type chain_ctl;
   key_type       head_key;
   key_type       back_key;
   logic          out_free;
   logic          accept;
   logic          is_full;
   logic          is_zero;
   mode_type      mode;
   logic          emit;
   key_type       emit_key;
   logic          emit_empty;
   logic          emit_ovf;
   logic          emit_last;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE) && out_free;
   assign accept = req_bus.valid && req_bus.ready;
   assign is_full = (count_ff == CNT_W'(DEPTH));
   assign is_zero = (count_ff == '0);
   assign mode = mode_type'(req_bus.mode);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && mode == MODE_DUMP && !is_zero) begin
               state_in = ST_DUMP;
            end
         end
         ST_DUMP: begin
            if (out_free && dump_left_ff == CNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      chain_ctl.op    = OP_HOLD;
      chain_ctl.key   = req_bus.key_in;
      chain_ctl.count = count_ff;
      count_in        = count_ff;
      dump_left_in    = dump_left_ff;
      emit            = 1'b0;
      emit_key        = '0;
      emit_empty      = 1'b0;
      emit_ovf        = 1'b0;
      emit_last       = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (mode)
                  MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                     if (is_full) begin
                        emit     = 1'b1;
                        emit_ovf = 1'b1;
                     end else begin
                        chain_ctl.op = (mode == MODE_PUSH_FRONT) ? OP_PUSH_FRONT
                                                                 : OP_PUSH_BACK;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  MODE_DUMP: begin
                     if (is_zero) begin
                        emit       = 1'b1;
                        emit_empty = 1'b1;
                     end else begin
                        dump_left_in = count_ff;
                     end
                  end
                  MODE_POP_FRONT: begin
                     emit = 1'b1;
                     if (is_zero) begin
                        emit_empty = 1'b1;
                     end else begin
                        emit_key     = head_key;
                        chain_ctl.op = OP_POP_FRONT;
                        count_in     = count_ff - CNT_W'(1);
                     end
                  end
                  MODE_POP_BACK: begin
                     emit = 1'b1;
                     if (is_zero) begin
                        emit_empty = 1'b1;
                     end else begin
                        emit_key = back_key;
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  default: begin
                     emit = 1'b0;
                  end
               endcase
            end
         end
         ST_DUMP: begin
            if (out_free) begin
               emit         = 1'b1;
               emit_key     = head_key;
               emit_last    = (dump_left_ff == CNT_W'(1));
               chain_ctl.op = OP_ROTATE;
               dump_left_in = dump_left_ff - CNT_W'(1);
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_key_in   = rsp_key_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_key_in   = emit_key;
         rsp_empty_in = emit_empty;
         rsp_ovf_in   = emit_ovf;
         rsp_last_in  = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         dump_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_left_ff <= dump_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_key_ff   <= rsp_key_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_last_ff  <= rsp_last_in;
   end

   dqe_chain u_chain (
      .clock    (clock),
      .ctl      (chain_ctl),
      .head_key (head_key),
      .back_key (back_key)
   );

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.key_out  = rsp_key_ff;
   assign rsp_bus.is_empty = rsp_empty_ff;
   assign rsp_bus.overflow = rsp_ovf_ff;
   assign rsp_bus.is_last  = rsp_last_ff;

endmodule

`default_nettype wire

### dv/double_ended_queue_core_tb.sv
// double_ended_queue_core_tb: self-checking bench for the byte-key deque core
// drives operation beats with burst pacing, predicts result beats with a shadow ring store
// depends on dqe_pkg, dqe_if and double_ended_queue_core
`timescale 1ns / 100ps

module double_ended_queue_core_tb;
   import dqe_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [MODE_W-1:0] MODE_RESERVED_BASE = 3'd5;
   localparam int NUM_RESERVED = 3;

   typedef logic [IDX_W-1:0] idx_type;

   typedef struct packed {
      key_type key_out;
      logic    is_empty;
      logic    overflow;
      logic    is_last;
   } rsp_beat_type;

   logic clock;
   logic reset;

   dqe_req_if req_bus ();
   dqe_rsp_if rsp_bus ();

   double_ended_queue_core u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // shadow deque state
   key_type      shadow_keys [DEPTH];
   idx_type      shadow_front;
   cnt_type      shadow_count;
   rsp_beat_type pending_beats [$];

   int  mismatch_count;
   int  items_sent;
   int  beats_checked;
   int  overflow_beats;
   int  empty_beats;
   int  burst_left;
   int  burst_max;
   int  gap_max;
   int  ready_pct;
   bit  hold_off;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      #5_000_000;
      $display("%0t timeout, %0d beats still pending", $time, pending_beats.size());
      $display("*** FAILED ***");
      $finish;
   end

   function automatic rsp_beat_type make_beat(key_type key, logic empty, logic ovf,
                                              logic last);
      rsp_beat_type b;
      b.key_out  = key;
      b.is_empty = empty;
      b.overflow = ovf;
      b.is_last  = last;
      return b;
   endfunction

   function automatic idx_type slot_at(int offset);
      return idx_type'((int'(shadow_front) + offset) % DEPTH);
   endfunction

   task automatic predict_deque_op(input logic [MODE_W-1:0] mode, input key_type key);
      idx_type slot;
      case (mode)
         MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
            if (int'(shadow_count) >= DEPTH) begin
               pending_beats.push_back(make_beat('0, 1'b0, 1'b1, 1'b1));
            end else begin
               if (mode == MODE_PUSH_FRONT) begin
                  shadow_front = idx_type'((int'(shadow_front) + DEPTH - 1) % DEPTH);
                  shadow_keys[shadow_front] = key;
               end else begin
                  shadow_keys[slot_at(int'(shadow_count))] = key;
               end
               shadow_count = shadow_count + 1'b1;
            end
         end
         MODE_DUMP: begin
            if (shadow_count == 0) begin
               pending_beats.push_back(make_beat('0, 1'b1, 1'b0, 1'b1));
            end else begin
               for (int i = 0; i < int'(shadow_count); i++) begin
                  pending_beats.push_back(make_beat(shadow_keys[slot_at(i)], 1'b0, 1'b0,
                                                    (i + 1 == int'(shadow_count))));
               end
            end
         end
         MODE_POP_FRONT: begin
            if (shadow_count == 0) begin
               pending_beats.push_back(make_beat('0, 1'b1, 1'b0, 1'b1));
            end else begin
               pending_beats.push_back(make_beat(shadow_keys[shadow_front], 1'b0, 1'b0, 1'b1));
               shadow_front = slot_at(1);
               shadow_count = shadow_count - 1'b1;
            end
         end
         MODE_POP_BACK: begin
            if (shadow_count == 0) begin
               pending_beats.push_back(make_beat('0, 1'b1, 1'b0, 1'b1));
            end else begin
               slot = slot_at(int'(shadow_count) - 1);
               pending_beats.push_back(make_beat(shadow_keys[slot], 1'b0, 1'b0, 1'b1));
               shadow_count = shadow_count - 1'b1;
            end
         end
         default: begin
         end
      endcase
   endtask

   // one operation beat, then an optional gap at the end of a burst
   task automatic send_op(input logic [MODE_W-1:0] mode, input key_type key);
      int gap;
      req_bus.valid  <= 1'b1;
      req_bus.mode   <= mode;
      req_bus.key_in <= key;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_deque_op(mode, key);
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, burst_max);
         gap = $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_drain();
      req_bus.valid <= 1'b0;
      for (int n = 0; n < 50000 && pending_beats.size() != 0; n++) @(posedge clock);
      repeat (DEPTH + 8) @(posedge clock);
   endtask

   task automatic set_pacing(int b_max, int g_max, int r_pct);
      burst_max  = b_max;
      gap_max    = g_max;
      ready_pct  <= r_pct;
      burst_left = 1;
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_beat_type got;
      rsp_beat_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got = make_beat(rsp_bus.key_out, rsp_bus.is_empty, rsp_bus.overflow, rsp_bus.is_last);
         if (pending_beats.size() == 0) begin
            mismatch_count++;
            $display("%0t unexpected beat: key_out %02h is_empty %0b overflow %0b is_last %0b",
                     $time, got.key_out, got.is_empty, got.overflow, got.is_last);
         end else begin
            want = pending_beats.pop_front();
            beats_checked++;
            if (got.overflow === 1'b1) overflow_beats++;
            if (got.is_empty === 1'b1) empty_beats++;
            if (got.key_out !== want.key_out || got.is_empty !== want.is_empty ||
                got.overflow !== want.overflow || got.is_last !== want.is_last) begin
               mismatch_count++;
               $display("%0t mismatch: expected key %02h e%0b o%0b l%0b, got key %02h e%0b o%0b l%0b",
                        $time, want.key_out, want.is_empty, want.overflow, want.is_last,
                        got.key_out, got.is_empty, got.overflow, got.is_last);
            end
         end
      end
   end

   // receiver: random runs of ready/stall, forced low during a hold-off
   initial begin
      int run_left;
      bit ready_level;
      run_left = 0;
      ready_level = 1'b1;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_bus.ready <= 1'b0;
         end else begin
            if (run_left == 0) begin
               ready_level = ($urandom_range(0, 99) < ready_pct);
               run_left = $urandom_range(1, 8);
            end
            run_left--;
            rsp_bus.ready <= ready_level;
         end
      end
   end

   task automatic test_directed();
      set_pacing(4, 2, 70);
      send_op(MODE_POP_FRONT, 8'h3c);
      send_op(MODE_POP_BACK, 8'hc3);
      send_op(MODE_DUMP, 8'hff);
      for (int k = 0; k < NUM_RESERVED; k++) begin
         send_op(MODE_RESERVED_BASE + MODE_W'(k), key_type'(8'h55 ^ k));
      end
      // one-entry queue popped from each end
      send_op(MODE_PUSH_BACK, 8'ha5);
      send_op(MODE_POP_BACK, 8'h00);
      send_op(MODE_PUSH_FRONT, 8'h5a);
      send_op(MODE_POP_FRONT, 8'h00);
      send_op(MODE_POP_BACK, 8'h00);
      send_op(MODE_PUSH_FRONT, 8'h00);
      send_op(MODE_PUSH_BACK, 8'hff);
      send_op(MODE_PUSH_FRONT, 8'h80);
      send_op(MODE_PUSH_BACK, 8'h01);
      send_op(MODE_DUMP, 8'h00);
      send_op(MODE_POP_BACK, 8'h00);
      send_op(MODE_POP_FRONT, 8'h00);
      send_op(MODE_POP_FRONT, 8'h00);
      send_op(MODE_POP_BACK, 8'h00);
      send_op(MODE_DUMP, 8'h00);
      wait_drain();
   endtask

   task automatic test_full_queue();
      set_pacing(1000, 0, 100);
      for (int i = 0; i < DEPTH / 2; i++) begin
         send_op(MODE_PUSH_BACK, key_type'($urandom_range(0, 255)));
      end
      for (int i = 0; i < DEPTH / 2; i++) begin
         send_op(MODE_PUSH_FRONT, key_type'($urandom_range(0, 255)));
      end
      send_op(MODE_PUSH_BACK, 8'hee);
      send_op(MODE_PUSH_FRONT, 8'h11);
      send_op(MODE_DUMP, 8'h00);
      send_op(MODE_POP_BACK, 8'h00);
      send_op(MODE_PUSH_BACK, 8'h7e);
      send_op(MODE_PUSH_FRONT, 8'h81);
      set_pacing(3, 3, 50);
      send_op(MODE_DUMP, 8'h00);
      for (int i = 0; i < DEPTH; i++) begin
         send_op((i % 2) ? MODE_POP_BACK : MODE_POP_FRONT, 8'h00);
      end
      send_op(MODE_POP_FRONT, 8'h00);
      wait_drain();
   endtask

   task automatic test_backpressure();
      set_pacing(1000, 0, 100);
      for (int i = 0; i < 8; i++) send_op(MODE_PUSH_BACK, key_type'($urandom_range(0, 255)));
      fork
         begin
            hold_off <= 1'b1;
            repeat (300) @(posedge clock);
            hold_off <= 1'b0;
         end
         begin
            for (int i = 0; i < 16; i++) begin
               send_op((i % 3 == 2) ? MODE_DUMP :
                       (i % 2) ? MODE_POP_BACK : MODE_POP_FRONT, 8'h00);
            end
         end
      join
      wait_drain();
   endtask

   task automatic test_random_mix(int count, int push_pct, int dump_pct);
      int r;
      logic [MODE_W-1:0] mode;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 4) begin
            mode = MODE_RESERVED_BASE + MODE_W'($urandom_range(0, NUM_RESERVED - 1));
         end
         else if (r < 4 + dump_pct) mode = MODE_DUMP;
         else if (r < 4 + dump_pct + push_pct)
            mode = $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
         else mode = $urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT;
         send_op(mode, key_type'($urandom_range(0, 255)));
      end
      wait_drain();
   endtask

   initial begin
      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.mode   <= MODE_PUSH_FRONT;
      req_bus.key_in <= '0;
      hold_off       <= 1'b0;
      ready_pct      <= 100;
      shadow_front   = '0;
      shadow_count   = '0;
      mismatch_count = 0;
      items_sent     = 0;
      beats_checked  = 0;
      overflow_beats = 0;
      empty_beats    = 0;
      burst_max      = 4;
      gap_max        = 2;
      burst_left     = 1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_full_queue();
      test_backpressure();
      set_pacing(6, 4, 70);
      test_random_mix(25, 45, 6);
      set_pacing(10, 2, 85);
      test_random_mix(20, 75, 4);
      set_pacing(5, 5, 40);
      test_random_mix(20, 20, 4);

      if (pending_beats.size() != 0) begin
         mismatch_count++;
         $display("%0t %0d expected beats never arrived", $time, pending_beats.size());
      end
      $display("covered %0d operation beats and %0d result beats (%0d overflow, %0d empty)",
               items_sent, beats_checked, overflow_beats, empty_beats);
      $display("including full-queue wrap, long receiver hold-off and %0d mismatches",
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
